// File: src/wls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weld line sequencer package
// Shared types, codes and the fixed transition table of the weld line
// sequencer.
// ----------------------------------------------------------------------------
package wls_pkg;

   localparam int MAX_POINTS     = 16;
   localparam int TIMER_BITS     = 16;
   localparam int LIMIT_BITS     = 16;
   localparam int POINT_BITS     = 5;
   localparam int COUNT_BITS     = 32;
   localparam int ROWS           = 16;
   localparam int ROW_BITS       = 5;
   localparam int CFG_INDEX_BITS = 3;
   localparam int CFG_DATA_BITS  = 16;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 104;

   localparam logic [ROW_BITS-1:0]   NO_ROW     = ROW_BITS'(ROWS);
   localparam logic [POINT_BITS-1:0] MAX_POINTS_VAL = POINT_BITS'(MAX_POINTS);

   typedef enum logic [2:0] {
      ST_OFF      = 3'd0,
      ST_IDLE     = 3'd1,
      ST_CLAMP    = 3'd2,
      ST_POSITION = 3'd3,
      ST_WELD     = 3'd4,
      ST_RELEASE  = 3'd5,
      ST_FAULT    = 3'd6,
      ST_STOPPED  = 3'd7
   } state_type;

   typedef enum logic [2:0] {
      EV_TICK     = 3'd0,
      EV_POWER_ON = 3'd1,
      EV_STOP     = 3'd2,
      EV_OBJECT   = 3'd3,
      EV_CLAMPED  = 3'd4,
      EV_ARRIVED  = 3'd5,
      EV_RELEASED = 3'd6,
      EV_RESET    = 3'd7
   } event_type;

   typedef enum logic [3:0] {
      DO_POWER_ON    = 4'd0,
      DO_STOP        = 4'd1,
      DO_CLAMP       = 4'd2,
      DO_MOVE        = 4'd3,
      DO_WELD        = 4'd4,
      DO_POINT_DONE  = 4'd5,
      DO_NEXT_OBJECT = 4'd6,
      DO_FAULT       = 4'd7,
      DO_RESET       = 4'd8
   } action_type;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      CFG_CLAMP_TIMEOUT   = 3'd0,
      CFG_MOVE_TIMEOUT    = 3'd1,
      CFG_WELD_DURATION   = 3'd2,
      CFG_RELEASE_TIMEOUT = 3'd3,
      CFG_PIECE_POINTS    = 3'd4
   } cfg_index_type;

   typedef struct packed {
      state_type  src;
      event_type  ev;
      state_type  dst;
      action_type act;
   } row_type;

   // Actuator levels, conveyor in the lowest bit.
   typedef struct packed {
      logic alarm;
      logic clamp;
      logic head;
      logic torch;
      logic conveyor;
   } levels_type;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] clamp_timeout;
      logic [LIMIT_BITS-1:0] move_timeout;
      logic [LIMIT_BITS-1:0] weld_duration;
      logic [LIMIT_BITS-1:0] release_timeout;
      logic [POINT_BITS-1:0] piece_points;
   } cfg_type;

   typedef struct packed {
      logic                fire;
      logic                to_release;
      logic [ROW_BITS-1:0] row_idx;
      state_type           dst;
      action_type          act;
   } decision_type;

   function automatic row_type row_def(input logic [3:0] idx);
      row_type r;
      unique case (idx)
         4'd0:  r = '{ST_OFF,      EV_POWER_ON, ST_IDLE,     DO_POWER_ON};
         4'd1:  r = '{ST_IDLE,     EV_OBJECT,   ST_CLAMP,    DO_CLAMP};
         4'd2:  r = '{ST_IDLE,     EV_STOP,     ST_STOPPED,  DO_STOP};
         4'd3:  r = '{ST_CLAMP,    EV_CLAMPED,  ST_POSITION, DO_MOVE};
         4'd4:  r = '{ST_CLAMP,    EV_TICK,     ST_FAULT,    DO_FAULT};
         4'd5:  r = '{ST_CLAMP,    EV_STOP,     ST_STOPPED,  DO_STOP};
         4'd6:  r = '{ST_POSITION, EV_ARRIVED,  ST_WELD,     DO_WELD};
         4'd7:  r = '{ST_POSITION, EV_TICK,     ST_FAULT,    DO_FAULT};
         4'd8:  r = '{ST_POSITION, EV_STOP,     ST_STOPPED,  DO_STOP};
         4'd9:  r = '{ST_WELD,     EV_TICK,     ST_POSITION, DO_POINT_DONE};
         4'd10: r = '{ST_WELD,     EV_STOP,     ST_STOPPED,  DO_STOP};
         4'd11: r = '{ST_RELEASE,  EV_RELEASED, ST_IDLE,     DO_NEXT_OBJECT};
         4'd12: r = '{ST_RELEASE,  EV_TICK,     ST_FAULT,    DO_FAULT};
         4'd13: r = '{ST_RELEASE,  EV_STOP,     ST_STOPPED,  DO_STOP};
         4'd14: r = '{ST_FAULT,    EV_RESET,    ST_IDLE,     DO_RESET};
         4'd15: r = '{ST_FAULT,    EV_STOP,     ST_STOPPED,  DO_STOP};
         default: r = '{ST_OFF,    EV_POWER_ON, ST_IDLE,     DO_POWER_ON};
      endcase
      return r;
   endfunction

endpackage

// File: src/wls_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weld line sequencer configuration registers
// Holds the four timing limits and the point count per workpiece.
// ----------------------------------------------------------------------------
module wls_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [wls_pkg::CFG_INDEX_BITS-1:0]   csr_index,
   input  logic [wls_pkg::CFG_DATA_BITS-1:0]    csr_data,
   output wls_pkg::cfg_type                     cfg
);
   import wls_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CFG_CLAMP_TIMEOUT:   cfg_in.clamp_timeout   = csr_data[LIMIT_BITS-1:0];
            CFG_MOVE_TIMEOUT:    cfg_in.move_timeout    = csr_data[LIMIT_BITS-1:0];
            CFG_WELD_DURATION:   cfg_in.weld_duration   = csr_data[LIMIT_BITS-1:0];
            CFG_RELEASE_TIMEOUT: cfg_in.release_timeout = csr_data[LIMIT_BITS-1:0];
            CFG_PIECE_POINTS:    cfg_in.piece_points    = csr_data[POINT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clamp_timeout   <= LIMIT_BITS'(100);
         cfg_ff.move_timeout    <= LIMIT_BITS'(100);
         cfg_ff.weld_duration   <= LIMIT_BITS'(10);
         cfg_ff.release_timeout <= LIMIT_BITS'(100);
         cfg_ff.piece_points    <= POINT_BITS'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/wls_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weld line sequencer transition decode
// Finds the table row for the current state and event, gates timed ticks
// and picks release over position after the last weld point.
// ----------------------------------------------------------------------------
module wls_decode (
   input  wls_pkg::state_type                  state,
   input  wls_pkg::event_type                  ev,
   input  logic [wls_pkg::TIMER_BITS-1:0]      timer,
   input  logic [wls_pkg::POINT_BITS-1:0]      point_count,
   input  wls_pkg::cfg_type                    cfg,
   output wls_pkg::decision_type               dec
);
   import wls_pkg::*;

   logic [LIMIT_BITS-1:0] limit;
   logic                  go;
   logic [ROWS-1:0]       match;
   row_type               probe;
   row_type               row;
   logic [POINT_BITS-1:0] total;
   logic [POINT_BITS:0]   next_point;

   always_comb begin
      unique case (state)
         ST_CLAMP:    limit = cfg.clamp_timeout;
         ST_POSITION: limit = cfg.move_timeout;
         ST_WELD:     limit = cfg.weld_duration;
         ST_RELEASE:  limit = cfg.release_timeout;
         default:     limit = '0;
      endcase
   end

   // A tick only counts when the state's limit is not zero and has been reached.
   assign go = (ev != EV_TICK) ||
               ((limit != '0) && (32'(timer) >= 32'(limit)));

   always_comb begin
      probe = row_def(4'd0);
      for (int i = 0; i < ROWS; i++) begin
         probe    = row_def(4'(i));
         match[i] = (probe.src == state) && (probe.ev == ev);
      end
   end

   always_comb begin
      dec.fire    = 1'b0;
      dec.row_idx = NO_ROW;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (match[i] && go) begin
            dec.fire    = 1'b1;
            dec.row_idx = ROW_BITS'(i);
         end
      end
      row     = row_def(dec.row_idx[3:0]);
      dec.act = row.act;
      dec.dst = row.dst;

      total      = (cfg.piece_points > MAX_POINTS_VAL) ? MAX_POINTS_VAL : cfg.piece_points;
      next_point = {1'b0, point_count} + (POINT_BITS+1)'(1);
      dec.to_release = dec.fire && (state == ST_WELD) && (ev == EV_TICK) &&
                       (next_point >= {1'b0, total});
      if (dec.to_release) begin
         dec.dst = ST_RELEASE;
      end
   end

endmodule

// File: src/weld_line_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weld line sequencer
// Table-driven spot-welding line controller: one event in, one status
// result out, with actuator levels, counters and transition coverage.
// ----------------------------------------------------------------------------
// A request transfer loads the request register, and when the event
// advances, its result is loaded into the response register; a stall of
// the response register holds the event back. Throughput: one event per
// cycle while the response register is not stalled; the single decode
// stage between the request and response registers sets that figure.
// Reset (synchronous, active high) puts the line in off with every actuator
// low, clears timer, counters and coverage, and reloads the default limits.
// ----------------------------------------------------------------------------
module weld_line_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel, tdata: event_code[2:0], zeros above.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [wls_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // Response channel, tdata from bit 0 up: line_state[2:0], conveyor_on,
   // torch_on, head_on, clamp_on, alarm_on, point_number[4:0],
   // pieces_done[31:0], faults_seen[31:0], fired_transition[4:0],
   // coverage_bits[15:0], zeros above.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wls_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wls_pkg::CFG_INDEX_BITS-1:0]   csr_index,
   input  logic [wls_pkg::CFG_DATA_BITS-1:0]    csr_data
);
   import wls_pkg::*;

   // Configuration writes: always taken; user keeps them to idle, unchecked.
   cfg_type cfg;
   assign csr_ready = 1'b1;

   wls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Request register. An event sits here until the response register can
   // take its result; advance marks the cycle in which it is processed.
   logic      in_valid_ff, in_valid_in;
   event_type event_ff;
   logic      req_xfer;
   logic      advance;

   // Sequencer state, updated only when an event advances.
   state_type             state_ff,   state_in;
   logic [TIMER_BITS-1:0] timer_ff,   timer_in;
   logic [POINT_BITS-1:0] point_ff,   point_in;
   logic [COUNT_BITS-1:0] done_ff,    done_in;
   logic [COUNT_BITS-1:0] faults_ff,  faults_in;
   levels_type            levels_ff,  levels_in;
   logic [ROWS-1:0]       covered_ff, covered_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff,  rsp_data_in;

   logic [TIMER_BITS-1:0] timer_inc;
   logic [ROW_BITS-1:0]   fired;
   decision_type          dec;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   // The dwell timer counts every event and sticks at its top value.
   assign timer_inc = (timer_ff != '1) ? timer_ff + TIMER_BITS'(1) : timer_ff;

   wls_decode u_decode (
      .state       (state_ff),
      .ev          (event_ff),
      .timer       (timer_inc),
      .point_count (point_ff),
      .cfg         (cfg),
      .dec         (dec)
   );

   // Apply the action of the row that fired, if any.
   always_comb begin
      state_in   = state_ff;
      timer_in   = timer_inc;
      point_in   = point_ff;
      done_in    = done_ff;
      faults_in  = faults_ff;
      levels_in  = levels_ff;
      covered_in = covered_ff;
      if (dec.fire) begin
         unique case (dec.act)
            DO_POWER_ON: begin
               levels_in.conveyor = 1'b1;
               levels_in.alarm    = 1'b0;
            end
            DO_STOP: begin
               levels_in.conveyor = 1'b0;
               levels_in.torch    = 1'b0;
               levels_in.head     = 1'b0;
               levels_in.clamp    = 1'b0;
            end
            DO_CLAMP: begin
               levels_in.clamp    = 1'b1;
               levels_in.conveyor = 1'b0;
               point_in           = '0;
            end
            DO_MOVE: begin
               levels_in.clamp = 1'b1;
               levels_in.head  = 1'b1;
            end
            DO_WELD: begin
               levels_in.torch = 1'b1;
               levels_in.head  = 1'b0;
            end
            DO_POINT_DONE: begin
               levels_in.torch = 1'b0;
               point_in        = point_ff + POINT_BITS'(1);
            end
            DO_NEXT_OBJECT: begin
               levels_in.conveyor = 1'b1;
               done_in            = done_ff + COUNT_BITS'(1);
            end
            DO_FAULT: begin
               levels_in.alarm    = 1'b1;
               levels_in.conveyor = 1'b0;
               levels_in.torch    = 1'b0;
               levels_in.head     = 1'b0;
               faults_in          = faults_ff + COUNT_BITS'(1);
            end
            DO_RESET: begin
               levels_in.conveyor = 1'b1;
               levels_in.alarm    = 1'b0;
               levels_in.clamp    = 1'b0;
               point_in           = '0;
            end
            default: ;
         endcase
         // The last weld point of a piece also opens the clamp.
         if (dec.to_release) begin
            levels_in.torch = 1'b0;
            levels_in.clamp = 1'b0;
         end
         state_in   = dec.dst;
         timer_in   = '0;
         covered_in = covered_ff | (ROWS'(1) << dec.row_idx[3:0]);
      end
   end

   assign fired = dec.fire ? dec.row_idx : NO_ROW;

   assign rsp_data_in = {6'b0, covered_in, fired, faults_in, done_in, point_in,
                         levels_in, state_in};

   // A new request fills the register; otherwise an advancing one empties it.
   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_OFF;
         timer_ff     <= '0;
         point_ff     <= '0;
         done_ff      <= '0;
         faults_ff    <= '0;
         levels_ff    <= '0;
         covered_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff   <= state_in;
            timer_ff   <= timer_in;
            point_ff   <= point_in;
            done_ff    <= done_in;
            faults_ff  <= faults_in;
            levels_ff  <= levels_in;
            covered_ff <= covered_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         event_ff <= event_type'(req_tdata[2:0]);
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Coverage marks are sticky until reset.
   a_coverage_sticky : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((covered_ff & $past(covered_ff)) == $past(covered_ff)))
      else $error("coverage bit cleared without reset");

   // The line can only sit in fault with the alarm sounding.
   a_fault_alarm : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FAULT) |-> levels_ff.alarm)
      else $error("fault state without alarm");

   // The point count never runs past the per-piece maximum.
   a_point_range : assert property (@(posedge clock) disable iff (reset)
      point_ff <= MAX_POINTS_VAL)
      else $error("point count out of range");

   // A held response must not be overwritten by a processed event.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("response overwritten while stalled");

endmodule
